// ----- src/running_mean_highpass_macros.svh -----
// assertion macros for the running mean high-pass block
// used by the checker module, no other dependencies
`ifndef RUNNING_MEAN_HIGHPASS_MACROS_SVH
`define RUNNING_MEAN_HIGHPASS_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define RMH_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("running_mean_highpass: assertion failed");

// next-cycle implication, disabled while reset is high
`define RMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("running_mean_highpass: assertion failed");

`endif

// ----- src/rmh_pkg.sv -----
// types, constants and microcode table for the running mean high-pass block
// no dependencies
package rmh_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRACTION_BITS = 16;
  localparam int COUNT_BITS    = 16;

  localparam int AVG_BITS  = SAMPLE_BITS + FRACTION_BITS;
  localparam int NUM_BITS  = AVG_BITS + COUNT_BITS + 1;
  localparam int DIFF_BITS = AVG_BITS + 1;
  localparam int OUT_BITS  = SAMPLE_BITS + 1;
  localparam int ITER_BITS = $clog2(AVG_BITS);
  localparam int STEP_BITS = 3;

  localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(100);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;
  } samp_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] filtered;
    logic                       block_end_out;
  } filt_t;

  // jump conditions of the sequencer
  typedef enum logic [3:0] {
    COND_NONE      = 4'b0001,
    COND_NO_SAMPLE = 4'b0010,
    COND_DIV_MORE  = 4'b0100,
    COND_OUT_BUSY  = 4'b1000
  } cond_t;

  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_WAIT = 3'd0;
  localparam step_t STEP_MUL  = 3'd1;
  localparam step_t STEP_ADD  = 3'd2;
  localparam step_t STEP_DIV  = 3'd3;
  localparam step_t STEP_FIX  = 3'd4;
  localparam step_t STEP_EMIT = 3'd5;

  // one control word: datapath enables, end-of-program flag, jump
  typedef struct packed {
    logic  accept;
    logic  mul;
    logic  load;
    logic  div;
    logic  commit;
    logic  emit;
    logic  last;
    cond_t cond;
    step_t target;
  } uword_t;

  // jump to target while cond holds, else fall through (or wrap on last)
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{accept: 1'b0, mul: 1'b0, load: 1'b0, div: 1'b0, commit: 1'b0,
          emit: 1'b0, last: 1'b0, cond: COND_NONE, target: STEP_WAIT};
    case (s)
      STEP_WAIT: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_SAMPLE;
        w.target = STEP_WAIT;
      end
      STEP_MUL:  w.mul = 1'b1;
      STEP_ADD:  w.load = 1'b1;
      STEP_DIV: begin
        w.div    = 1'b1;
        w.cond   = COND_DIV_MORE;
        w.target = STEP_DIV;
      end
      STEP_FIX:  w.commit = 1'b1;
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.last   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      default:   w.last = 1'b1;
    endcase
    return w;
  endfunction

endpackage

// ----- src/running_mean_highpass.sv -----
// running mean high-pass: sample minus a cumulative / exponential running average
// depends on rmh_pkg; microcoded sequencer with a 40-step restoring divider
// sequence of steps: wait for a sample, multiply, load the divider, divide, commit, emit
// one sample at a time; a new one is taken only once its result is in the output register
// reset (rst, synchronous): average and warm-up count cleared, window back to 100
module running_mean_highpass (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rmh_pkg::COUNT_BITS-1:0]  cfg_data,
  input  logic                            samp_valid,
  output logic                            samp_ready,
  input  rmh_pkg::samp_t                  samp_data,
  output logic                            filt_valid,
  input  logic                            filt_ready,
  output rmh_pkg::filt_t                  filt_data
);
  import rmh_pkg::*;

  // architectural state
  logic        [COUNT_BITS-1:0] window;
  logic signed [AVG_BITS-1:0]   avg;
  logic        [COUNT_BITS-1:0] count;

  // sequencer
  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   cond_true;
  logic   out_busy;

  // datapath registers
  logic signed [SAMPLE_BITS-1:0] x;
  logic                          blk;
  logic signed [NUM_BITS-1:0]    prod;
  logic                          warm;
  logic        [COUNT_BITS-1:0]  divisor;
  logic                          neg;
  logic        [COUNT_BITS-1:0]  rem;
  logic        [AVG_BITS-1:0]    quo;
  logic        [ITER_BITS-1:0]   iter;

  // datapath logic
  logic        [COUNT_BITS-1:0]  w_eff;
  logic                          warm_now;
  logic        [COUNT_BITS-1:0]  factor;
  logic        [COUNT_BITS-1:0]  divisor_now;
  logic signed [AVG_BITS-1:0]    xf;
  logic signed [NUM_BITS-1:0]    num;
  logic        [NUM_BITS-1:0]    mag;
  logic        [COUNT_BITS:0]    shifted;
  logic        [COUNT_BITS:0]    trial;
  logic signed [DIFF_BITS-1:0]   diff;
  logic signed [DIFF_BITS-1:0]   bias;
  logic signed [DIFF_BITS-1:0]   biased;
  logic signed [DIFF_BITS-1:0]   res;

  // configuration taken whenever out of reset; the user must write it only while the block is idle, not enforced here
  assign cfg_ready = !rst;

  // control word of the current step
  assign uw = ucode(step);

  // input is taken only in the wait step, never during reset
  assign samp_ready = uw.accept && !rst;

  // result register still occupied at the end of this cycle
  assign out_busy = filt_valid && !filt_ready;

  always_comb begin
    case (uw.cond)
      COND_NONE:      cond_true = 1'b0;
      COND_NO_SAMPLE: cond_true = !samp_valid;
      COND_DIV_MORE:  cond_true = (iter != ITER_BITS'(AVG_BITS - 1));
      COND_OUT_BUSY:  cond_true = out_busy;
      default:        cond_true = 1'b0;
    endcase
    if (cond_true) begin
      step_next = uw.target;
    end else if (uw.last) begin
      step_next = STEP_WAIT;
    end else begin
      step_next = step + STEP_BITS'(1);
    end
  end

  // a zero window behaves as a window of one
  assign w_eff       = (window == '0) ? COUNT_BITS'(1) : window;
  // warm-up: cumulative mean, multiply by count and divide by count+1
  assign warm_now    = (count < w_eff);
  assign factor      = warm_now ? count : (w_eff - COUNT_BITS'(1));
  assign divisor_now = warm_now ? (count + COUNT_BITS'(1)) : w_eff;

  // sample in average fixed point
  assign xf  = AVG_BITS'(x) <<< FRACTION_BITS;
  // numerator and its magnitude for the unsigned divider
  assign num = prod + NUM_BITS'(xf);
  assign mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);

  // one restoring division step
  assign shifted = {rem, quo[AVG_BITS-1]};
  assign trial   = shifted - {1'b0, divisor};

  // filtered output: truncate toward zero by biasing negatives before the shift
  assign diff   = DIFF_BITS'(xf) - DIFF_BITS'(avg);
  assign bias   = diff[DIFF_BITS-1] ? DIFF_BITS'((64'd1 << FRACTION_BITS) - 64'd1) : '0;
  assign biased = diff + bias;
  assign res    = biased >>> FRACTION_BITS;

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= STEP_WAIT;
      window <= WINDOW_RESET;
      avg    <= '0;
      count  <= '0;
    end else begin
      step <= step_next;
      if (cfg_valid && cfg_ready) begin
        window <= cfg_data;
      end
      // write back the new average, bump the count during warm-up
      if (uw.commit) begin
        avg <= neg ? AVG_BITS'(-$signed(quo)) : AVG_BITS'($signed(quo));
        if (warm) begin
          count <= count + COUNT_BITS'(1);
        end
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (samp_valid && samp_ready) begin
      x   <= samp_data.sample;
      blk <= samp_data.block_end;
    end
    // avg times count (warm-up) or times window-1
    if (uw.mul) begin
      prod    <= avg * $signed({1'b0, factor});
      warm    <= warm_now;
      divisor <= divisor_now;
    end
    // quotient fits the average width, so the top bits start as remainder
    if (uw.load) begin
      neg  <= num[NUM_BITS-1];
      rem  <= mag[NUM_BITS-2:AVG_BITS];
      quo  <= mag[AVG_BITS-1:0];
      iter <= '0;
    end
    if (uw.div) begin
      if (!trial[COUNT_BITS]) begin
        rem <= trial[COUNT_BITS-1:0];
        quo <= {quo[AVG_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[COUNT_BITS-1:0];
        quo <= {quo[AVG_BITS-2:0], 1'b0};
      end
      iter <= iter + ITER_BITS'(1);
    end
  end

  // output register: loaded in the emit step once free, cleared on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      filt_valid <= 1'b0;
    end else begin
      if (filt_valid && filt_ready) begin
        filt_valid <= 1'b0;
      end
      if (uw.emit && !out_busy) begin
        filt_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uw.emit && !out_busy) begin
      filt_data.filtered      <= res[OUT_BITS-1:0];
      filt_data.block_end_out <= blk;
    end
  end

endmodule

// ----- src/rmh_checker.sv -----
// port-level checker for running_mean_highpass, bound to the top level
// depends on rmh_pkg and running_mean_highpass_macros.svh
`include "running_mean_highpass_macros.svh"

module rmh_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            samp_valid,
  input logic                            samp_ready,
  input logic                            filt_valid,
  input logic                            filt_ready,
  input rmh_pkg::filt_t                  filt_data
);
  import rmh_pkg::*;

  // one sample in flight: no new transfer right after one
  `RMH_ASSERT_NEXT(a_one_at_a_time, clk, rst, samp_valid && samp_ready, !samp_ready)
  // sequencer comes out of reset waiting for a sample
  `RMH_ASSERT_IMPL(a_ready_after_reset, clk, rst, $fell(rst), samp_ready)
  // a result never appears right after the sample transfer
  `RMH_ASSERT_NEXT(a_no_quick_result, clk, rst, samp_valid && samp_ready && !filt_valid, !filt_valid)
  // stalled result stays valid and unchanged
  `RMH_ASSERT_NEXT(a_result_held, clk, rst, filt_valid && !filt_ready, filt_valid)
  `RMH_ASSERT_NEXT(a_payload_held, clk, rst, filt_valid && !filt_ready, $stable(filt_data))

endmodule

bind running_mean_highpass rmh_checker u_rmh_checker (.*);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for running_mean_highpass: directed and random samples checked against
// a bit-exact predictor of the cumulative / exponential running average
// depends on rmh_pkg and the running_mean_highpass rtl
module tb_top;
  import rmh_pkg::*;

  // predictor plus store of expected filter outputs
  class highpass_scoreboard;
    logic signed [AVG_BITS-1:0] average;
    logic [COUNT_BITS-1:0]      warmup;
    logic [COUNT_BITS-1:0]      window;
    filt_t                      pending[$];
    int                         mismatches;
    int                         checked;

    function new();
      average    = '0;
      warmup     = '0;
      window     = WINDOW_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_window(logic [COUNT_BITS-1:0] w);
      window = w;
    endfunction

    // update the running average with one accepted sample, queue the output it gives
    function void note_sample(samp_t s);
      longint scale;
      longint x_fixed;
      longint avg_prev;
      longint count;
      longint win;
      longint avg_next;
      longint res;
      filt_t  want;
      scale    = longint'(1) << FRACTION_BITS;
      x_fixed  = $signed(s.sample);
      x_fixed  = x_fixed * scale;
      avg_prev = average;
      count    = warmup;
      // a zero window behaves as a window of one
      win      = (window == '0) ? 1 : window;
      if (count < win) begin
        // warm-up: cumulative mean, count advances
        avg_next = (avg_prev * count + x_fixed) / (count + 1);
        warmup   = warmup + 1'b1;
      end else begin
        // exponential form, count held (also after the window was lowered)
        avg_next = (avg_prev * (win - 1) + x_fixed) / win;
      end
      average = avg_next[AVG_BITS-1:0];
      res = (x_fixed - avg_next) / scale;
      want.filtered      = res[OUT_BITS-1:0];
      want.block_end_out = s.block_end;
      pending.push_back(want);
    endfunction

    // compare one output transfer with the oldest expectation
    function void check_filtered(filt_t got);
      filt_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transfer: filtered %0d block_end_out %0b",
                   got.filtered, got.block_end_out);
        return;
      end
      want = pending.pop_front();
      if (got.filtered !== want.filtered) begin
        mismatches++;
        if (mismatches <= 10)
          $display("filtered mismatch at output %0d: expected %0d actual %0d",
                   checked, want.filtered, got.filtered);
      end
      if (got.block_end_out !== want.block_end_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("block_end_out mismatch at output %0d: expected %0b actual %0b",
                   checked, want.block_end_out, got.block_end_out);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [COUNT_BITS-1:0] cfg_data   = '0;
  logic                  samp_valid = 1'b0;
  logic                  samp_ready;
  samp_t                 samp_data  = '0;
  logic                  filt_valid;
  logic                  filt_ready = 1'b0;
  filt_t                 filt_data;

  // when set, neither side idles
  logic                  burst      = 1'b0;
  int                    samples_sent    = 0;
  int                    windows_written = 0;

  highpass_scoreboard sb;

  running_mean_highpass u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .samp_valid (samp_valid),
    .samp_ready (samp_ready),
    .samp_data  (samp_data),
    .filt_valid (filt_valid),
    .filt_ready (filt_ready),
    .filt_data  (filt_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard limit on the run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // one sample transfer; called and returns at a falling edge
  task automatic send_sample(int value, bit last_in_buffer);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      samp_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samp_data.sample    <= value[SAMPLE_BITS-1:0];
    samp_data.block_end <= last_in_buffer;
    samp_valid          <= 1'b1;
    // inputs are stable at the rising edge, ready is read before it updates
    do @(posedge clk); while (!samp_ready);
    sb.note_sample(samp_data);
    samples_sent++;
    @(negedge clk);
  endtask

  // window register write; only while the block is idle
  task automatic write_window(logic [COUNT_BITS-1:0] w);
    cfg_data  <= w;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_window(w);
    windows_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold off the sender until every expected output has arrived
  task automatic wait_for_outputs();
    samp_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // output side: random stalls, every transfer checked
  initial begin : receiver
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        filt_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      filt_ready <= 1'b1;
      do @(posedge clk); while (!filt_valid);
      sb.check_filtered(filt_data);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int                    random_items;
    int                    phase_len;
    int                    dc;
    int                    amp;
    int                    val;
    logic [COUNT_BITS-1:0] w;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset window of 100: sample extremes during warm-up, both flag values
    send_sample(8388607, 1'b0);
    send_sample(-8388608, 1'b1);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b1);
    send_sample(8388607, 1'b0);
    send_sample(8388607, 1'b0);
    send_sample(-8388608, 1'b0);
    send_sample(-8388608, 1'b0);
    send_sample(12345, 1'b1);
    send_sample(-12345, 0);
    send_sample(0, 1'b0);

    // zero window acts as one: average follows the sample, output zero
    wait_for_outputs();
    write_window('0);
    send_sample(8388607, 1'b0);
    send_sample(-8388608, 1'b1);
    send_sample(5000, 1'b0);
    send_sample(-1, 1'b0);

    // window of one
    wait_for_outputs();
    write_window(COUNT_BITS'(1));
    send_sample(-8388608, 1'b0);
    send_sample(8388607, 1'b1);
    send_sample(77, 1'b0);

    // window lowered below the warm-up count: exponential form, count held
    wait_for_outputs();
    write_window(COUNT_BITS'(4));
    send_sample(8388607, 1'b0);
    send_sample(-300000, 1'b0);
    send_sample(-8388608, 1'b1);

    // largest window: warm-up resumes from the kept count
    wait_for_outputs();
    write_window('1);
    send_sample(8388607, 1'b0);
    send_sample(-8388608, 1'b0);
    send_sample(4096, 1'b1);

    // random phases, each with its own window, dc level and idling mode
    random_items = 0;
    while (random_items < 700) begin
      wait_for_outputs();
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = COUNT_BITS'(1);
        2:       w = '1;
        3:       w = COUNT_BITS'(2);
        4, 5, 6: w = COUNT_BITS'($urandom_range(2, 64));
        7:       w = COUNT_BITS'($urandom_range(65, 2000));
        // at or below the current count
        8:       w = COUNT_BITS'($urandom_range(1, (sb.warmup > 1) ? sb.warmup : 1));
        default: w = COUNT_BITS'($urandom_range(1, 65535));
      endcase
      write_window(w);
      burst     = ($urandom_range(0, 3) == 0);
      dc        = int'($urandom_range(0, 8388607)) - 4194304;
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        case ($urandom_range(0, 9))
          0: val = $urandom();
          1: val = $urandom_range(0, 1) ? 8388607 : -8388608;
          default: begin
            // slowly varying signal: dc level plus bounded noise
            amp = 1 << $urandom_range(0, 14);
            val = dc - amp + int'($urandom_range(0, 2 * amp));
          end
        endcase
        send_sample(val, $urandom_range(0, 7) == 0);
        random_items++;
        // now and then let the pipeline run empty mid-phase
        if ($urandom_range(0, 49) == 0)
          wait_for_outputs();
      end
    end

    wait_for_outputs();
    burst = 1'b0;
    // room for any stray output after the last expected one
    repeat (60) @(negedge clk);

    $display("covered %0d samples across %0d window settings, %0d output transfers",
             samples_sent, windows_written, sb.checked);
    $display("zero, one, lowered and largest windows included, %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
